### hdl/pulsed_heading_turn_controller_core_macros.svh
// Assertion helpers used by the controller RTL (phtc_ctrl).
`ifndef PULSED_HEADING_TURN_CONTROLLER_CORE_MACROS_SVH
`define PULSED_HEADING_TURN_CONTROLLER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PHTC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PHTC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/phtc_pkg.sv
`default_nettype none

package phtc_pkg;

  localparam int ELAPSED_WIDTH_DEF = 17;
  localparam int TIMEOUT_W         = 17;
  localparam int CFG_DATA_W        = 17;
  localparam int CFG_IDX_W         = 3;
  localparam int PRODUCT_W         = 18;

  localparam int FULL_TURN = 3600;
  localparam int HALF_TURN = 1800;

  // floor(q / 225) == (q * RECIP_225) >> RECIP_SHIFT for q below 2^15
  localparam int RECIP_225   = 4772186;
  localparam int RECIP_SHIFT = 30;

  localparam logic [10:0] TOLERANCE_RST = 11'd50;
  localparam logic [6:0]  MIN_SPEED_RST = 7'd35;
  localparam logic [6:0]  MAX_SPEED_RST = 7'd50;
  localparam logic [15:0] PULSE_RST     = 16'd150;
  localparam logic [15:0] SETTLE_RST    = 16'd300;
  localparam logic [16:0] TIMEOUT_RST   = 17'd20000;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_STOP  = 2'd2,
    REQ_QUERY = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    STAT_IDLE     = 3'd0,
    STAT_PULSING  = 3'd1,
    STAT_SETTLING = 3'd2,
    STAT_ARRIVED  = 3'd3,
    STAT_TIMEOUT  = 3'd4,
    STAT_STOPPED  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_PULSE  = 2'd1,
    MODE_SETTLE = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    CFG_TOLERANCE = 3'd0,
    CFG_MIN_SPEED = 3'd1,
    CFG_MAX_SPEED = 3'd2,
    CFG_PULSE     = 3'd3,
    CFG_SETTLE    = 3'd4,
    CFG_TIMEOUT   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [10:0] tolerance_tenths;
    logic [6:0]  min_speed;
    logic [6:0]  max_speed;
    logic [15:0] pulse_ticks;
    logic [15:0] settle_ticks;
    logic [16:0] timeout_ticks;
  } cfg_t;

  // Item handed from the error stage to the sequencer.
  typedef struct packed {
    req_e                   req;
    logic                   arrived;
    logic                   neg;
    logic [PRODUCT_W-1:0]   product;
  } mid_t;

  typedef struct packed {
    logic signed [7:0] steer;
    status_e           status;
    logic              advance;
  } res_t;

endpackage

`default_nettype wire

### hdl/phtc_if.sv
`default_nettype none

interface phtc_req_if;
  logic                valid;
  logic                ready;
  logic [1:0]          req_type;
  logic signed [16:0]  target_tenths;
  logic [11:0]         heading_tenths;

  modport source (output valid, output req_type, output target_tenths,
                  output heading_tenths, input ready);
  modport sink (input valid, input req_type, input target_tenths,
                input heading_tenths, output ready);
endinterface

interface phtc_res_if;
  logic               valid;
  logic               ready;
  logic signed [7:0]  steer;
  logic [2:0]         status;
  logic               advance;

  modport source (output valid, output steer, output status, output advance,
                  input ready);
  modport sink (input valid, input steer, input status, input advance,
                output ready);
endinterface

`default_nettype wire

### hdl/phtc_front.sv
`default_nettype none

module phtc_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  phtc_pkg::cfg_t      cfg_i,
  phtc_req_if.sink            req_in,
  input  wire                 mid_take_i,
  output logic                mid_valid_o,
  output phtc_pkg::mid_t      mid_o
);

  typedef struct packed {
    phtc_pkg::req_e req;
    logic [11:0]    target;
    logic [11:0]    heading;
  } in_t;

  logic        iv_q, iv_d;
  in_t         in_q;
  logic        mv_q, mv_d;
  phtc_pkg::mid_t mid_q, mid_d;
  logic [11:0] tgt_q, tgt_d;
  logic        mid_ready;
  logic        in_take;

  // Wrap a signed target into 0..3599 by binary long division.
  function automatic logic [11:0] wrap_target(input logic signed [16:0] t);
    logic signed [18:0] s;
    logic [17:0]        u;
    s = 19'(t) + 19'sd68400;
    u = s[17:0];
    for (int i = 5; i >= 0; i--) begin
      if (u >= (18'(phtc_pkg::FULL_TURN) << i)) begin
        u = u - (18'(phtc_pkg::FULL_TURN) << i);
      end
    end
    return u[11:0];
  endfunction

  assign mid_ready    = !mv_q || mid_take_i;
  assign req_in.ready = !iv_q || mid_ready;
  assign in_take      = req_in.valid && req_in.ready;
  assign iv_d         = in_take ? 1'b1 : (mid_ready ? 1'b0 : iv_q);
  assign mv_d         = mid_ready ? iv_q : mv_q;

  // Target only moves on a start; track it as items leave the input stage.
  assign tgt_d = (iv_q && mid_ready && in_q.req == phtc_pkg::REQ_START) ?
                 in_q.target : tgt_q;

  always_comb begin
    logic [11:0] tgt_eff;
    logic [13:0] d;
    logic [11:0] r;
    logic [10:0] mag;
    logic [6:0]  span;
    tgt_eff = (in_q.req == phtc_pkg::REQ_START) ? in_q.target : tgt_q;
    d = 14'(tgt_eff) + 14'(2 * phtc_pkg::FULL_TURN) - 14'(in_q.heading);
    if (d >= 14'(2 * phtc_pkg::FULL_TURN)) begin
      d = d - 14'(2 * phtc_pkg::FULL_TURN);
    end
    if (d >= 14'(phtc_pkg::FULL_TURN)) begin
      d = d - 14'(phtc_pkg::FULL_TURN);
    end
    r = d[11:0];
    // Fold into (-1800, 1800]: keep magnitude and sign apart.
    if (r > 12'(phtc_pkg::HALF_TURN)) begin
      mag       = 11'(12'(phtc_pkg::FULL_TURN) - r);
      mid_d.neg = 1'b1;
    end else begin
      mag       = r[10:0];
      mid_d.neg = 1'b0;
    end
    span = (cfg_i.max_speed >= cfg_i.min_speed) ?
           (cfg_i.max_speed - cfg_i.min_speed) : 7'd0;
    mid_d.req     = in_q.req;
    mid_d.arrived = (mag <= cfg_i.tolerance_tenths);
    mid_d.product = phtc_pkg::PRODUCT_W'(mag) * phtc_pkg::PRODUCT_W'(span);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q  <= 1'b0;
      mv_q  <= 1'b0;
      tgt_q <= '0;
    end else begin
      iv_q  <= iv_d;
      mv_q  <= mv_d;
      tgt_q <= tgt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.req     <= phtc_pkg::req_e'(req_in.req_type);
      in_q.target  <= wrap_target(req_in.target_tenths);
      in_q.heading <= req_in.heading_tenths;
    end
    if (iv_q && mid_ready) begin
      mid_q <= mid_d;
    end
  end

  assign mid_valid_o = mv_q;
  assign mid_o       = mid_q;

endmodule

`default_nettype wire

### hdl/phtc_ctrl.sv
`default_nettype none

`include "pulsed_heading_turn_controller_core_macros.svh"

module phtc_ctrl #(
  parameter int ELAPSED_WIDTH = phtc_pkg::ELAPSED_WIDTH_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  phtc_pkg::cfg_t      cfg_i,
  input  wire                 mid_valid_i,
  input  phtc_pkg::mid_t      mid_i,
  output logic                mid_take_o,
  phtc_res_if.source          res_out
);

  localparam int CMP_W = (ELAPSED_WIDTH > phtc_pkg::TIMEOUT_W) ?
                         ELAPSED_WIDTH : phtc_pkg::TIMEOUT_W;
  localparam int QW    = phtc_pkg::PRODUCT_W - 3;
  localparam int RW    = QW + 23;

  phtc_pkg::mode_e          mode_q, mode_d;
  logic [15:0]              phase_q, phase_d;
  logic [ELAPSED_WIDTH-1:0] elapsed_q, elapsed_d, elapsed_inc;
  logic signed [7:0]        held_q, held_d;
  logic                     ov_q;
  phtc_pkg::res_t           res_q, res_d;

  logic                     out_adv;
  logic                     take;
  logic [RW-1:0]            recip;
  logic [6:0]               quot;
  logic [7:0]               speed;
  logic signed [7:0]        eval_steer;
  logic [15:0]              pulse_load, settle_load;
  logic                     timed_out;

  assign out_adv    = !ov_q || res_out.ready;
  assign take       = mid_valid_i && out_adv;
  assign mid_take_o = out_adv;

  // Speed = min + floor(|e| * span / 1800); divide by 8 then by 225.
  assign recip      = RW'(mid_i.product[phtc_pkg::PRODUCT_W-1:3]) *
                      RW'(phtc_pkg::RECIP_225);
  assign quot       = recip[phtc_pkg::RECIP_SHIFT +: 7];
  assign speed      = 8'(cfg_i.min_speed) + 8'(quot);
  assign eval_steer = mid_i.neg ? -$signed(speed) : $signed(speed);

  assign pulse_load  = (cfg_i.pulse_ticks == 16'd0) ? 16'd1 : cfg_i.pulse_ticks;
  assign settle_load = (cfg_i.settle_ticks == 16'd0) ? 16'd1 : cfg_i.settle_ticks;

  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
  assign timed_out   = CMP_W'(elapsed_inc) > CMP_W'(cfg_i.timeout_ticks);

  // Next state.
  always_comb begin
    mode_d    = mode_q;
    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    held_d    = held_q;
    if (take) begin
      case (mid_i.req)
        phtc_pkg::REQ_START: begin
          elapsed_d = '0;
          if (mid_i.arrived) begin
            mode_d = phtc_pkg::MODE_IDLE;
            held_d = '0;
          end else begin
            mode_d  = phtc_pkg::MODE_PULSE;
            held_d  = eval_steer;
            phase_d = pulse_load;
          end
        end
        phtc_pkg::REQ_TICK: begin
          if (mode_q != phtc_pkg::MODE_IDLE) begin
            elapsed_d = elapsed_inc;
            if (phase_q > 16'd1) begin
              phase_d = phase_q - 16'd1;
            end else if (mode_q == phtc_pkg::MODE_PULSE) begin
              mode_d  = phtc_pkg::MODE_SETTLE;
              phase_d = settle_load;
            end else if (timed_out || mid_i.arrived) begin
              mode_d = phtc_pkg::MODE_IDLE;
              held_d = '0;
            end else begin
              mode_d  = phtc_pkg::MODE_PULSE;
              held_d  = eval_steer;
              phase_d = pulse_load;
            end
          end
        end
        phtc_pkg::REQ_STOP: begin
          mode_d  = phtc_pkg::MODE_IDLE;
          held_d  = '0;
          phase_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Result of the item under evaluation.
  always_comb begin
    res_d.steer   = '0;
    res_d.status  = phtc_pkg::STAT_IDLE;
    res_d.advance = 1'b0;
    case (mid_i.req)
      phtc_pkg::REQ_START: begin
        if (mid_i.arrived) begin
          res_d.status  = phtc_pkg::STAT_ARRIVED;
          res_d.advance = 1'b1;
        end else begin
          res_d.steer  = eval_steer;
          res_d.status = phtc_pkg::STAT_PULSING;
        end
      end
      phtc_pkg::REQ_TICK: begin
        if (mode_q == phtc_pkg::MODE_IDLE) begin
          res_d.status = phtc_pkg::STAT_IDLE;
        end else if (phase_q > 16'd1) begin
          if (mode_q == phtc_pkg::MODE_PULSE) begin
            res_d.steer  = held_q;
            res_d.status = phtc_pkg::STAT_PULSING;
          end else begin
            res_d.status = phtc_pkg::STAT_SETTLING;
          end
        end else if (mode_q == phtc_pkg::MODE_PULSE) begin
          res_d.status = phtc_pkg::STAT_SETTLING;
        end else if (timed_out) begin
          res_d.status  = phtc_pkg::STAT_TIMEOUT;
          res_d.advance = 1'b1;
        end else if (mid_i.arrived) begin
          res_d.status  = phtc_pkg::STAT_ARRIVED;
          res_d.advance = 1'b1;
        end else begin
          res_d.steer  = eval_steer;
          res_d.status = phtc_pkg::STAT_PULSING;
        end
      end
      phtc_pkg::REQ_STOP: begin
        res_d.status = phtc_pkg::STAT_STOPPED;
      end
      default: begin
        case (mode_q)
          phtc_pkg::MODE_PULSE: begin
            res_d.steer  = held_q;
            res_d.status = phtc_pkg::STAT_PULSING;
          end
          phtc_pkg::MODE_SETTLE: res_d.status = phtc_pkg::STAT_SETTLING;
          default:               res_d.status = phtc_pkg::STAT_IDLE;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= phtc_pkg::MODE_IDLE;
      phase_q   <= '0;
      elapsed_q <= '0;
      held_q    <= '0;
      ov_q      <= 1'b0;
    end else begin
      mode_q    <= mode_d;
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      held_q    <= held_d;
      if (out_adv) begin
        ov_q <= mid_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  assign res_out.valid   = ov_q;
  assign res_out.steer   = res_q.steer;
  assign res_out.status  = res_q.status;
  assign res_out.advance = res_q.advance;

  `PHTC_ASSERT_IMP(a_adv_only_at_end, clk_i, rst_ni, ov_q && res_q.advance,
    res_q.status == phtc_pkg::STAT_ARRIVED || res_q.status == phtc_pkg::STAT_TIMEOUT,
    "advance raised on a result that does not end a turn")
  `PHTC_ASSERT_IMP(a_steer_only_pulse, clk_i, rst_ni, ov_q && res_q.steer != 8'sd0,
    res_q.status == phtc_pkg::STAT_PULSING, "steer driven outside a pulse")
  `PHTC_ASSERT_IMP(a_idle_no_steer, clk_i, rst_ni, mode_q == phtc_pkg::MODE_IDLE,
    held_q == 8'sd0, "held steer left over in idle")
  `PHTC_ASSERT_IMP(a_phase_live, clk_i, rst_ni, mode_q != phtc_pkg::MODE_IDLE,
    phase_q != 16'd0, "pulse or settle phase with empty count")
  `PHTC_ASSERT_NXT(a_start_clears, clk_i, rst_ni,
    take && mid_i.req == phtc_pkg::REQ_START, elapsed_q == '0,
    "start did not clear elapsed ticks")

endmodule

`default_nettype wire

### hdl/pulsed_heading_turn_controller_core.sv
// Pulsed heading turn controller: bang-bang compass turn in tenths of a degree.
// Channels: req_in carries one request per transfer (start with a target,
// tick with the current compass heading, stop, query); res_out returns exactly one
// result per request: steer percent, status code and the advance flag.
// Configuration registers (tolerance, speeds, pulse, settle and timeout
// ticks) are written through cfg_we_i/cfg_idx_i/cfg_data_i; the user writes
// them only while idle (the block does not enforce it); unknown indexes are ignored.
// A result is presented once its request has passed the input register, the
// error register and the result register, in that order.
// Throughput: one request per cycle unless res_out stalls; each stage holds one
// item and moves whenever the stage after it is empty or moving, so a new request
// is taken while a finished result still waits in the result register.
// When res_out stalls, results hold and the stages fill up; req_in.ready
// drops only once all three stages are occupied.
// Reset (rst_ni low, asynchronous) empties the pipeline, returns the turn
// to idle with zero target, count, elapsed ticks and steer, and loads the
// register defaults.
`default_nettype none

module pulsed_heading_turn_controller_core #(
  parameter int ELAPSED_WIDTH = phtc_pkg::ELAPSED_WIDTH_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire [phtc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire [phtc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  phtc_req_if.sink                            req_in,
  phtc_res_if.source                          res_out
);

  phtc_pkg::cfg_t cfg_q;
  logic           mid_valid;
  logic           mid_take;
  phtc_pkg::mid_t mid;

  // Register file: one write per enabled cycle, no read-back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tolerance_tenths <= phtc_pkg::TOLERANCE_RST;
      cfg_q.min_speed        <= phtc_pkg::MIN_SPEED_RST;
      cfg_q.max_speed        <= phtc_pkg::MAX_SPEED_RST;
      cfg_q.pulse_ticks      <= phtc_pkg::PULSE_RST;
      cfg_q.settle_ticks     <= phtc_pkg::SETTLE_RST;
      cfg_q.timeout_ticks    <= phtc_pkg::TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (phtc_pkg::cfg_idx_e'(cfg_idx_i))
        phtc_pkg::CFG_TOLERANCE: cfg_q.tolerance_tenths <= cfg_data_i[10:0];
        phtc_pkg::CFG_MIN_SPEED: cfg_q.min_speed        <= cfg_data_i[6:0];
        phtc_pkg::CFG_MAX_SPEED: cfg_q.max_speed        <= cfg_data_i[6:0];
        phtc_pkg::CFG_PULSE:     cfg_q.pulse_ticks      <= cfg_data_i[15:0];
        phtc_pkg::CFG_SETTLE:    cfg_q.settle_ticks     <= cfg_data_i[15:0];
        phtc_pkg::CFG_TIMEOUT:   cfg_q.timeout_ticks    <= cfg_data_i[16:0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  // Wrap the target, form the shortest error and the speed product.
  phtc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .req_in      (req_in),
    .mid_take_i  (mid_take),
    .mid_valid_o (mid_valid),
    .mid_o       (mid)
  );

  // Pulse / settle sequencing, speed scaling and the result register.
  phtc_ctrl #(
    .ELAPSED_WIDTH (ELAPSED_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .mid_valid_i (mid_valid),
    .mid_i       (mid),
    .mid_take_o  (mid_take),
    .res_out     (res_out)
  );

endmodule

`default_nettype wire
